// ===== src/laq_pkg.sv =====
// ============================================================================
// laq_pkg
// Shared constants of the level ancestor query unit.
// ============================================================================
package laq_pkg;

    localparam int MAX_NODES   = 4096;
    localparam int LEVEL_COUNT = 4096;
    localparam int FIELD_W     = 12;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

endpackage

// ===== src/laq_ram.sv =====
// ============================================================================
// laq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module laq_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/level_ancestor_query_unit.sv =====
// ============================================================================
// level_ancestor_query_unit
// Depth table with per-level population counters and a backward scan query.
// ============================================================================
// Operation: clear sweeps the population table, one entry a cycle; append
// does a read-modify-write of the population entry; query reads the node's
// depth and the level population, then one depth memory read per scanned node.
// One item at a time; the depth memory read port sets the scan rate.
// Reset: synchronous active low; starts a population clearing sweep of
// all 4096 entries during which no item is accepted.
module level_ancestor_query_unit #(
    parameter int MAX_NODES = laq_pkg::MAX_NODES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // node_depth[11:0], probe_node[23:12], probe_level[35:24]
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // ancestor[11:0], zero fill
    output logic        m_axis_tuser   // not_found
);

    localparam int AW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int LW  = laq_pkg::FIELD_W;
    localparam int PW  = 13;

    typedef enum logic [6:0] {
        ST_CLR   = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_APRD  = 7'b0000100,
        ST_APWR  = 7'b0001000,
        ST_QRD   = 7'b0010000,
        ST_QCHK  = 7'b0100000,
        ST_SCAN  = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    logic [LW:0]     r_clr, n_clr;
    logic [CW-1:0]   r_total, n_total;
    logic [LW-1:0]   r_dep, n_dep;
    logic [LW-1:0]   r_lvl, n_lvl;
    logic [AW:0]     r_j, n_j;
    logic            r_ovalid, n_ovalid;
    logic [LW-1:0]   r_anc, n_anc;
    logic            r_nf, n_nf;

    logic            d_we;
    logic [AW-1:0]   d_waddr, d_raddr;
    logic [LW-1:0]   d_rdata;
    logic            p_we;
    logic [LW-1:0]   p_waddr, p_raddr;
    logic [PW-1:0]   p_wdata, p_rdata;

    laq_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_depth (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_waddr), .i_wdata(r_dep),
        .i_raddr(d_raddr), .o_rdata(d_rdata)
    );

    laq_ram #(.WIDTH(PW), .DEPTH(laq_pkg::LEVEL_COUNT)) u_pop (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_rdata)
    );

    logic in_fire;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Next-state and memory control
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_total  = r_total;
        n_dep    = r_dep;
        n_lvl    = r_lvl;
        n_j      = r_j;
        n_ovalid = r_ovalid;
        n_anc    = r_anc;
        n_nf     = r_nf;
        d_we     = 1'b0;
        d_waddr  = r_total[AW-1:0];
        d_raddr  = r_j[AW-1:0];
        p_we     = 1'b0;
        p_waddr  = r_clr[LW-1:0];
        p_wdata  = '0;
        p_raddr  = r_dep;
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            ST_CLR: begin
                p_we  = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr[LW-1:0] == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    n_dep = s_axis_tdata[11:0];
                    n_lvl = s_axis_tdata[35:24];
                    n_j   = (AW+1)'(s_axis_tdata[23:12]);
                    case (s_axis_tuser)
                        laq_pkg::KIND_CLEAR: begin
                            n_total = '0;
                            n_clr   = '0;
                            n_state = ST_CLR;
                        end
                        laq_pkg::KIND_APPEND: begin
                            if (r_total != CW'(MAX_NODES)) begin
                                n_state = ST_APRD;
                            end
                        end
                        laq_pkg::KIND_QUERY: begin
                            if ({12'd0, s_axis_tdata[23:12]} >= 24'(r_total)) begin
                                n_ovalid = 1'b1;
                                n_anc    = '0;
                                n_nf     = 1'b1;
                            end else begin
                                n_state = ST_QRD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_APRD: begin
                // population read issued; write depth table
                d_we    = 1'b1;
                n_total = r_total + 1'b1;
                n_state = ST_APWR;
            end
            ST_APWR: begin
                p_we    = 1'b1;
                p_waddr = r_dep;
                p_wdata = p_rdata + 1'b1;
                n_state = ST_IDLE;
            end
            ST_QRD: begin
                // depth of the node itself and population of the level
                p_raddr = r_lvl;
                n_state = ST_QCHK;
            end
            ST_QCHK: begin
                if (d_rdata == r_lvl) begin
                    n_ovalid = 1'b1;
                    n_anc    = LW'(r_j);
                    n_nf     = 1'b0;
                    n_state  = ST_IDLE;
                end else if (p_rdata == '0 || r_j == '0) begin
                    n_ovalid = 1'b1;
                    n_anc    = '0;
                    n_nf     = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_j     = r_j - 1'b1;
                    d_raddr = AW'(r_j - 1'b1);
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // r_j is the index whose depth arrives now
                if (d_rdata == r_lvl) begin
                    n_ovalid = 1'b1;
                    n_anc    = LW'(r_j);
                    n_nf     = 1'b0;
                    n_state  = ST_IDLE;
                end else if (r_j == '0) begin
                    n_ovalid = 1'b1;
                    n_anc    = '0;
                    n_nf     = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_j     = r_j - 1'b1;
                    d_raddr = AW'(r_j - 1'b1);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_clr    <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_total  <= n_total;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_dep <= n_dep;
        r_lvl <= n_lvl;
        r_j   <= n_j;
        r_anc <= n_anc;
        r_nf  <= n_nf;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'b0, r_anc};
    assign m_axis_tuser  = r_nf;

    // Node count never exceeds capacity
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(MAX_NODES)) else $error("node count overflow");
    // No input taken while a result waits
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !s_axis_tready) else $error("accept with pending result");
    // Held result stays stable under stall
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> $stable(r_anc) && $stable(r_nf))
        else $error("result changed while stalled");

endmodule

// ===== tb/level_ancestor_query_unit_tb.sv =====
// ============================================================================
// level_ancestor_query_unit_tb
// Streams clear, append and query beats into the unit, predicts each query
// answer from a local depth table, and compares every result beat in order.
// ============================================================================
`timescale 1ns / 100ps

module level_ancestor_query_unit_tb;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 5000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] node_depth;
        logic [11:0] probe_node;
        logic [11:0] probe_level;
    } t_laq_item;

    typedef struct packed {
        logic [11:0] ancestor;
        logic        not_found;
    } t_laq_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // node_depth[11:0], probe_node[23:12], probe_level[35:24]
    logic [1:0]  s_axis_tuser = '0;  // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;       // ancestor[11:0], zero fill
    logic        m_axis_tuser;       // not_found

    t_laq_item   pending_items[$];
    t_laq_answer expected_answers[$];
    logic [11:0] model_depths[laq_pkg::MAX_NODES];
    int          model_total = 0;
    int          level_count[laq_pkg::LEVEL_COUNT];
    int          send_idle_pct = 17;
    int          recv_idle_pct = 75;
    bit          send_hold = 1'b0;
    int          error_count = 0;
    int          query_count = 0;
    int          found_count = 0;
    int          item_count = 0;
    int          cycle_count = 0;

    level_ancestor_query_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one accepted beat to the local table; queue an answer for a query
    task automatic apply_item(input t_laq_item it);
        t_laq_answer ans;
        int j;
        if (it.kind == laq_pkg::KIND_CLEAR) begin
            model_total = 0;
            foreach (level_count[k]) level_count[k] = 0;
        end else if (it.kind == laq_pkg::KIND_APPEND) begin
            if (model_total < laq_pkg::MAX_NODES) begin
                model_depths[model_total] = it.node_depth;
                model_total++;
                level_count[it.node_depth]++;
            end
        end else if (it.kind == laq_pkg::KIND_QUERY) begin
            ans = '{ancestor: 12'd0, not_found: 1'b1};
            if (int'(it.probe_node) < model_total) begin
                if (model_depths[it.probe_node] == it.probe_level) begin
                    ans = '{ancestor: it.probe_node, not_found: 1'b0};
                end else if (level_count[it.probe_level] != 0) begin
                    for (j = int'(it.probe_node) - 1; j >= 0; j--) begin
                        if (model_depths[j] == it.probe_level) begin
                            ans = '{ancestor: j[11:0], not_found: 1'b0};
                            break;
                        end
                    end
                end
            end
            query_count++;
            if (!ans.not_found) found_count++;
            expected_answers.push_back(ans);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    // Drive the input stream; advance to the next item after each accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_item(t_laq_item'({s_axis_tuser, s_axis_tdata[11:0],
                                        s_axis_tdata[23:12], s_axis_tdata[35:24]}));
                item_count++;
            end
            if ((!s_axis_tvalid || s_axis_tready) && pending_items.size() > 0
                    && !(send_hold && expected_answers.size() > 0)
                    && $urandom_range(99) >= send_idle_pct) begin
                t_laq_item it;
                it = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= it.kind;
                s_axis_tdata  <= {4'd0, it.probe_level, it.probe_node, it.node_depth};
            end else if (s_axis_tready) begin
                s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every result beat against the oldest expected answer
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_answers.size() == 0) begin
                report_mismatch($sformatf("unexpected result anc=%0d nf=%0b",
                                          m_axis_tdata[11:0], m_axis_tuser));
            end else begin
                t_laq_answer exp_ans;
                exp_ans = expected_answers.pop_front();
                if (m_axis_tdata[11:0] !== exp_ans.ancestor)
                    report_mismatch($sformatf("ancestor %0d, want %0d",
                                              m_axis_tdata[11:0], exp_ans.ancestor));
                if (m_axis_tuser !== exp_ans.not_found)
                    report_mismatch($sformatf("not_found %0b, want %0b",
                                              m_axis_tuser, exp_ans.not_found));
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("level_ancestor_query_unit_tb: FAIL");
            $finish;
        end
    end

    function automatic t_laq_item make_item(input logic [1:0] k, input int d,
                                            input int q, input int l);
        make_item = '{kind: k, node_depth: d[11:0], probe_node: q[11:0], probe_level: l[11:0]};
    endfunction

    // Push a clear, a random preorder-like tree of n nodes, then qn queries
    task automatic push_tree(input int n, input int qn);
        int depth;
        depth = 0;
        pending_items.push_back(make_item(laq_pkg::KIND_CLEAR, 0, 0, 0));
        for (int i = 0; i < n; i++) begin
            pending_items.push_back(make_item(laq_pkg::KIND_APPEND, depth, 0, 0));
            depth = (i == n - 1) ? 0 : $urandom_range(depth + 1, (depth > 3) ? depth - 3 : 1);
            if ($urandom_range(9) == 0) depth = $urandom_range(4095);
        end
        for (int i = 0; i < qn; i++)
            pending_items.push_back(make_item(laq_pkg::KIND_QUERY, $urandom_range(4095),
                                              $urandom_range(n + 1),
                                              $urandom_range(3) == 0 ?
                                              $urandom_range(4095) : $urandom_range(8)));
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_answers.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        foreach (level_count[k]) level_count[k] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, empty level, missing node, unused kind, all bits
        pending_items.push_back(make_item(laq_pkg::KIND_QUERY, 0, 0, 0));
        pending_items.push_back(make_item(laq_pkg::KIND_APPEND, 0, 0, 0));
        pending_items.push_back(make_item(laq_pkg::KIND_APPEND, 4095, 0, 0));
        pending_items.push_back(make_item(laq_pkg::KIND_APPEND, 1, 0, 0));
        pending_items.push_back(make_item(laq_pkg::KIND_APPEND, 4095, 0, 0));
        pending_items.push_back(make_item(2'd3, 4095, 4095, 4095));
        pending_items.push_back(make_item(laq_pkg::KIND_QUERY, 0, 0, 0));
        pending_items.push_back(make_item(laq_pkg::KIND_QUERY, 4095, 3, 4095));
        pending_items.push_back(make_item(laq_pkg::KIND_QUERY, 0, 3, 0));
        pending_items.push_back(make_item(laq_pkg::KIND_QUERY, 0, 2, 4095));
        pending_items.push_back(make_item(laq_pkg::KIND_QUERY, 0, 3, 7));
        pending_items.push_back(make_item(laq_pkg::KIND_QUERY, 0, 0, 1));
        pending_items.push_back(make_item(laq_pkg::KIND_QUERY, 0, 4, 0));
        pending_items.push_back(make_item(laq_pkg::KIND_QUERY, 0, 4095, 0));
        pending_items.push_back(make_item(laq_pkg::KIND_CLEAR, 4095, 4095, 4095));
        pending_items.push_back(make_item(laq_pkg::KIND_QUERY, 0, 0, 0));

        // Random trees, first receiver-light then sender-light
        for (int r = 0; r < 8; r++) push_tree($urandom_range(2, 40), 15);
        wait_drained();
        // Hold each new beat until every pending answer is in
        send_hold = 1'b1;
        push_tree(30, 20);
        wait_drained();
        send_hold = 1'b0;
        send_idle_pct = 75;
        recv_idle_pct = 17;
        for (int r = 0; r < 8; r++) push_tree($urandom_range(2, 40), 15);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int r = 0; r < 2; r++) push_tree($urandom_range(2, 40), 15);
        // Query the far end of the index range
        pending_items.push_back(make_item(laq_pkg::KIND_QUERY, 0, 4095, 0));
        pending_items.push_back(make_item(laq_pkg::KIND_QUERY, 0, 4095, 4095));
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d beats: %0d queries, %0d with an ancestor found,", item_count,
                 query_count, found_count);
        $display("covering clears, unused kinds, missing nodes and empty levels.");
        if (error_count == 0 && expected_answers.size() == 0) begin
            $display("level_ancestor_query_unit_tb: PASS");
        end else begin
            $display("level_ancestor_query_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
